// ===== sv/rlmd_pkg.sv =====
// ----------------------------------------------------------------------------
// rlmd_pkg
// Shared types and constants of the run-length map directory: operation
// codes, the command broadcast to the cell row and the cell read word.
// ----------------------------------------------------------------------------
package rlmd_pkg;

	localparam int VAL_W = 8;
	localparam int OP_W  = 2;
	localparam int OFS_W = 8;
	localparam int CNT_W = 9;

	// value of every offset after reset
	localparam logic [VAL_W-1:0] UNASSIGNED_RST = 8'hFF;

	// operation codes; the unused code behaves as a query
	typedef enum logic [OP_W-1:0] {
		OP_QUERY = 2'd0,
		OP_SET   = 2'd1,
		OP_CLEAR = 2'd2
	} op_t;

	// command broadcast to all cells for one cycle
	typedef struct packed {
		logic             go;
		op_t              op;
		logic [VAL_W-1:0] value;
		logic [VAL_W-1:0] fill;
	} cmd_t;

	// neighborhood of the addressed offset, zero from every other cell
	typedef struct packed {
		logic [VAL_W-1:0] val;
		logic             start;
		logic             nxt_start;
		logic [VAL_W-1:0] nxt_val;
		logic [VAL_W-1:0] prv_val;
	} rd_t;

endpackage

// ===== sv/rlmd_if.sv =====
// ----------------------------------------------------------------------------
// rlmd_if
// Valid/ready channels of the run-length map directory: request, response
// and configuration write.
// ----------------------------------------------------------------------------
interface rlmd_req_if;
	import rlmd_pkg::*;
	logic             valid;
	logic             ready;
	logic [OP_W-1:0]  operation;
	logic [OFS_W-1:0] offset;
	logic [VAL_W-1:0] new_value;

	modport source(output valid, operation, offset, new_value, input ready);
	modport sink(input valid, operation, offset, new_value, output ready);
endinterface

interface rlmd_rsp_if;
	import rlmd_pkg::*;
	logic             valid;
	logic             ready;
	logic [VAL_W-1:0] prior_value;
	logic [CNT_W-1:0] run_count;

	modport source(output valid, prior_value, run_count, input ready);
	modport sink(input valid, prior_value, run_count, output ready);
endinterface

interface rlmd_cfg_if;
	import rlmd_pkg::*;
	logic             valid;
	logic             ready;
	logic [VAL_W-1:0] unassigned_value;

	modport source(output valid, unassigned_value, input ready);
	modport sink(input valid, unassigned_value, output ready);
endinterface

// ===== sv/rlmd_cell.sv =====
// ----------------------------------------------------------------------------
// rlmd_cell
// One offset of the directory: its value and its run-start bit. Updates
// itself from the broadcast command and the state of its two neighbors.
// ----------------------------------------------------------------------------
module rlmd_cell #(
	parameter int POS_W = 8,
	parameter int IDX   = 0
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  rlmd_pkg::cmd_t            cmd,
	input  logic [POS_W-1:0]          pos,
	input  logic [rlmd_pkg::VAL_W-1:0] left_val,
	input  logic                      right_start,
	input  logic [rlmd_pkg::VAL_W-1:0] right_val,
	output logic                      start_q,
	output logic [rlmd_pkg::VAL_W-1:0] val_q,
	output rlmd_pkg::rd_t             rd
);
	import rlmd_pkg::*;

	logic             at_pos;
	logic             after_pos;
	logic             start_d;
	logic [VAL_W-1:0] val_d;

	assign at_pos    = (pos == POS_W'(IDX));
	assign after_pos = (IDX != 0) && (pos == POS_W'(IDX - 1));

	// next state
	always_comb begin
		start_d = start_q;
		val_d   = val_q;
		if (cmd.go) begin
			case (cmd.op)
				OP_CLEAR: begin
					val_d   = cmd.fill;
					start_d = (IDX == 0);
				end
				OP_SET: begin
					// addressed offset: take the value, merge left or open a run
					if (at_pos && val_q != cmd.value) begin
						val_d   = cmd.value;
						start_d = !((IDX != 0) && start_q && left_val == cmd.value);
					end
					// offset after it: merge with an equal run or split off the rest
					if (after_pos && left_val != cmd.value) begin
						if (start_q) begin
							if (val_q == cmd.value) begin
								start_d = 1'b0;
							end
						end else begin
							start_d = 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= (IDX == 0);
			val_q   <= UNASSIGNED_RST;
		end else begin
			start_q <= start_d;
			val_q   <= val_d;
		end
	end

	// read word, only from the addressed cell
	always_comb begin
		rd = '0;
		if (at_pos) begin
			rd.val       = val_q;
			rd.start     = start_q;
			rd.nxt_start = right_start;
			rd.nxt_val   = right_val;
			rd.prv_val   = left_val;
		end
	end

endmodule

// ===== sv/rlmd_or_tree.sv =====
// ----------------------------------------------------------------------------
// rlmd_or_tree
// Two-level registered OR reduction that collects the read word of the
// addressed cell: groups first, then the group results.
// ----------------------------------------------------------------------------
module rlmd_or_tree #(
	parameter int ENTRIES = 256
) (
	input  logic          clk,
	input  logic          hold,
	input  rlmd_pkg::rd_t rd_in [ENTRIES],
	output rlmd_pkg::rd_t rd_s2
);
	import rlmd_pkg::*;

	localparam int GRP_BITS = ($clog2(ENTRIES) + 1) / 2;
	localparam int GROUP    = 1 << GRP_BITS;
	localparam int NGRP     = (ENTRIES + GROUP - 1) / GROUP;

	rd_t grp_d  [NGRP];
	rd_t grp_s1 [NGRP];
	rd_t all_d;

	// level one: OR inside each group
	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_d[g] = '0;
			for (int k = 0; k < GROUP; k++) begin
				if (g * GROUP + k < ENTRIES) begin
					grp_d[g] = grp_d[g] | rd_in[g * GROUP + k];
				end
			end
		end
	end

	// level two: OR over the groups
	always_comb begin
		all_d = '0;
		for (int g = 0; g < NGRP; g++) begin
			all_d = all_d | grp_s1[g];
		end
	end

	// both stages freeze while the collected word is still needed
	always_ff @(posedge clk) begin
		if (!hold) begin
			grp_s1 <= grp_d;
			rd_s2  <= all_d;
		end
	end

endmodule

// ===== sv/run_length_map_directory.sv =====
// Sequence: after an item is accepted, the cells update as the group OR stage
// takes the pre-update read word; the final OR stage follows, and DONE loads
// the output register. Items are taken only in IDLE, one at a time; a result
// waiting at the output stalls the next one in DONE.
// Reset: every offset holds 255 in one run, run count 1, unassigned value 255.
// ----------------------------------------------------------------------------
// run_length_map_directory
// Run-length map of ENTRIES offsets to 8-bit values, held in a row of cells
// with per-offset run-start bits, plus a running count of runs.
// ----------------------------------------------------------------------------
module run_length_map_directory #(
	parameter int ENTRIES = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	rlmd_req_if.sink   req,
	rlmd_rsp_if.source rsp,
	rlmd_cfg_if.sink   cfg
);
	import rlmd_pkg::*;

	localparam int POS_W = $clog2(ENTRIES);
	localparam int CW    = $clog2(ENTRIES + 1);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_CELL = 4'b0010,
		ST_TREE = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t           state_q;
	op_t              op_q;
	logic [POS_W-1:0] pos_q;
	logic [VAL_W-1:0] value_q;
	logic [VAL_W-1:0] unassigned_q;
	logic [CW-1:0]    runs_q;
	logic             out_vld_q;
	logic [VAL_W-1:0] prior_q;
	logic [CNT_W-1:0] count_q;

	logic             accept;
	logic             done_fire;
	logic             tree_hold;
	logic             ofs_big;
	logic [POS_W-1:0] pos_in;
	cmd_t             cmd;
	rd_t              rd_s2;
	logic             changed;
	logic             n_inc, n_dec, p_inc, p_dec;
	logic [CW-1:0]    runs_d;

	logic [VAL_W-1:0] cell_val   [ENTRIES];
	logic             cell_start [ENTRIES];
	rd_t              cell_rd    [ENTRIES];

	// configuration register, written only between items
	assign cfg.ready = (state_q == ST_IDLE);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unassigned_q <= UNASSIGNED_RST;
		end else if (cfg.valid && cfg.ready) begin
			unassigned_q <= cfg.unassigned_value;
		end
	end

	// input handshake and offset saturation
	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign ofs_big   = (32'(req.offset) >= ENTRIES);
	assign pos_in    = ofs_big ? POS_W'(ENTRIES - 1) : POS_W'(req.offset);

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= op_t'(req.operation);
			pos_q   <= pos_in;
			value_q <= req.new_value;
		end
	end

	// command to the cell row
	always_comb begin
		cmd.go    = (state_q == ST_CELL);
		cmd.op    = op_q;
		cmd.value = value_q;
		cmd.fill  = unassigned_q;
	end

	// cell row
	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		logic [VAL_W-1:0] left_val;
		logic             right_start;
		logic [VAL_W-1:0] right_val;

		if (i == 0) begin : g_first
			assign left_val = '0;
		end else begin : g_left
			assign left_val = cell_val[i-1];
		end
		if (i == ENTRIES - 1) begin : g_last
			assign right_start = 1'b0;
			assign right_val   = '0;
		end else begin : g_right
			assign right_start = cell_start[i+1];
			assign right_val   = cell_val[i+1];
		end

		rlmd_cell #(
			.POS_W(POS_W),
			.IDX  (i)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.pos        (pos_q),
			.left_val   (left_val),
			.right_start(right_start),
			.right_val  (right_val),
			.start_q    (cell_start[i]),
			.val_q      (cell_val[i]),
			.rd         (cell_rd[i])
		);
	end

	// read collection; the pre-update word is kept while DONE waits
	assign tree_hold = (state_q == ST_DONE);

	rlmd_or_tree #(
		.ENTRIES(ENTRIES)
	) u_tree (
		.clk  (clk),
		.hold (tree_hold),
		.rd_in(cell_rd),
		.rd_s2(rd_s2)
	);

	// run count change, from the pre-update neighborhood
	assign changed = (op_q == OP_SET) && (rd_s2.val != value_q);
	always_comb begin
		n_inc = 1'b0;
		n_dec = 1'b0;
		p_inc = 1'b0;
		p_dec = 1'b0;
		if (changed) begin
			if (pos_q != POS_W'(ENTRIES - 1)) begin
				if (rd_s2.nxt_start) begin
					n_dec = (rd_s2.nxt_val == value_q);
				end else begin
					n_inc = 1'b1;
				end
			end
			if (pos_q != '0 && rd_s2.start && rd_s2.prv_val == value_q) begin
				p_dec = 1'b1;
			end else if (!rd_s2.start) begin
				p_inc = 1'b1;
			end
		end
	end

	always_comb begin
		if (op_q == OP_CLEAR) begin
			runs_d = CW'(1);
		end else begin
			runs_d = runs_q + CW'(n_inc) + CW'(p_inc) - CW'(n_dec) - CW'(p_dec);
		end
	end

	assign done_fire = (state_q == ST_DONE) && (!out_vld_q || rsp.ready);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			runs_q  <= CW'(1);
		end else begin
			unique case (state_q)
				ST_IDLE: if (accept) state_q <= ST_CELL;
				ST_CELL: state_q <= ST_TREE;
				ST_TREE: state_q <= ST_DONE;
				ST_DONE: begin
					if (done_fire) begin
						state_q <= ST_IDLE;
						runs_q  <= runs_d;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (done_fire) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_fire) begin
			prior_q <= rd_s2.val;
			count_q <= CNT_W'(runs_d);
		end
	end

	assign rsp.valid       = out_vld_q;
	assign rsp.prior_value = prior_q;
	assign rsp.run_count   = count_q;

endmodule

// ===== sv/rlmd_chk.sv =====
// ----------------------------------------------------------------------------
// rlmd_chk
// Port-level checks of the run-length map directory, bound to the top level.
// ----------------------------------------------------------------------------
module rlmd_chk (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       req_valid,
	input logic                       req_ready,
	input logic                       rsp_valid,
	input logic                       rsp_ready,
	input logic [rlmd_pkg::VAL_W-1:0] prior_value,
	input logic [rlmd_pkg::CNT_W-1:0] run_count
);

	// a stalled result stays offered
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its payload
	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(prior_value) && $stable(run_count))
		else $error("result changed while stalled");

	// one item in flight: busy for the cycles that follow an accept
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready ##1 !req_ready ##1 !req_ready)
		else $error("item accepted while another is in flight");

	// at least one run always exists
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> run_count != '0)
		else $error("run count of zero");

endmodule

bind run_length_map_directory rlmd_chk u_rlmd_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.prior_value(rsp.prior_value),
	.run_count  (rsp.run_count)
);
